// ===== design/btg_pkg.sv =====
// shared types and constants for the bytebeat tone generator
package btg_pkg;

    localparam int PERIOD_WIDTH = 16;
    localparam int DATA_W       = 32;
    localparam int IN_W         = 16;
    localparam int ALG_W        = 8;
    localparam int OFFSET_W     = 15;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 15;
    localparam int DIV_CNT_W    = $clog2(DATA_W);

    localparam logic [ALG_W-1:0] ALG_CODE_F0 = 8'd0;
    localparam logic [ALG_W-1:0] ALG_CODE_F1 = 8'd1;
    localparam logic [ALG_W-1:0] ALG_CODE_F2 = 8'd2;

    localparam logic [DATA_W-1:0] F0_MUL_C   = 32'd351;
    localparam logic [DATA_W-1:0] F0_SUB_C   = 32'd528;
    localparam logic [DATA_W-1:0] F0_MOD_C   = 32'd6;
    localparam logic [DATA_W-1:0] F0_BASE_C  = 32'd2;
    localparam logic [DATA_W-1:0] F0_MASK_C  = 32'd200;
    localparam logic [DATA_W-1:0] F2_DIV_C   = 32'd3;
    localparam logic [DATA_W-1:0] F2_BASE_C  = 32'd7;

    // floor(x / 3) = (x * RECIP3_C) >> RECIP3_SHIFT for any 32-bit x
    localparam logic [DATA_W-1:0] RECIP3_C     = 32'hAAAA_AAAB;
    localparam int                RECIP3_SHIFT = 33;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALGORITHM    = 1'b0,
        CFG_START_OFFSET = 1'b1
    } btg_cfg_idx_t;

    typedef enum logic [1:0] {
        ALG_F0,
        ALG_F1,
        ALG_F2,
        ALG_PASS
    } btg_alg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TICK,
        OP_F0_MUL351,
        OP_DIV_TM,
        OP_F0_MOD6,
        OP_F0_MULAK,
        OP_F0_MUL200,
        OP_F0_FIN,
        OP_F1_MUL,
        OP_F1_FIN,
        OP_F2_DIV3,
        OP_F2_SQ,
        OP_MUL_XY,
        OP_DIV_XD,
        OP_F2_FIN,
        OP_PASS_FIN
    } btg_op_t;

    typedef struct packed {
        btg_op_t op;
        logic    load_out;
    } btg_cmd_t;

    typedef struct packed {
        logic     wrap;
        logic     div_busy;
        btg_alg_t alg;
    } btg_status_t;

endpackage

// ===== design/btg_divider.sv =====
// restoring divider, one quotient bit per cycle
module btg_divider (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [btg_pkg::DATA_W-1:0] dividend,
    input  logic [btg_pkg::DATA_W-1:0] divisor,
    output logic                       busy,
    output logic [btg_pkg::DATA_W-1:0] quotient,
    output logic [btg_pkg::DATA_W-1:0] remainder
);
    import btg_pkg::*;

    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic                 busy_reg, busy_next;
    logic [DATA_W:0]      trial;
    logic [DATA_W:0]      diff;

    assign trial = {rem_reg, quo_reg[DATA_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        if (start) begin
            quo_next   = dividend;
            rem_next   = '0;
            dvs_next   = divisor;
            count_next = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            // zero divisor leaves the dividend as remainder
            if (!diff[DATA_W]) begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            count_next = count_reg + 1'b1;
            if (count_reg == DIV_CNT_W'(DATA_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

endmodule

// ===== design/btg_datapath.sv =====
// phase counter, formula datapath, configuration and output registers
module btg_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  btg_pkg::btg_cmd_t              cmd,
    output btg_pkg::btg_status_t           status,
    input  logic                           cfg_wr_en,
    input  logic [btg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [btg_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [btg_pkg::IN_W-1:0]       s_period_samples,
    output logic [btg_pkg::DATA_W-1:0]     m_sample_value,
    output logic                           m_fresh_value
);
    import btg_pkg::*;

    logic [ALG_W-1:0]        algorithm_reg, algorithm_next;
    logic [OFFSET_W-1:0]     offset_reg, offset_next;
    logic [PERIOD_WIDTH-1:0] phase_reg, phase_next;
    logic [PERIOD_WIDTH-1:0] period_hold_reg, period_hold_next;
    logic [DATA_W-1:0]       step_reg, step_next;
    logic [DATA_W-1:0]       held_reg, held_next;
    logic                    fresh_reg, fresh_next;
    logic [DATA_W-1:0]       t_reg, t_next;
    logic [DATA_W-1:0]       x_reg, x_next;
    logic [DATA_W-1:0]       y_reg, y_next;
    logic [DATA_W-1:0]       out_value_reg;
    logic                    out_fresh_reg;

    logic [PERIOD_WIDTH:0]   phase_inc;
    logic                    wrap;
    logic [PERIOD_WIDTH-1:0] period_in;
    logic                    div_start;
    logic [DATA_W-1:0]       div_dividend;
    logic [DATA_W-1:0]       div_divisor;
    logic                    div_busy;
    logic [DATA_W-1:0]       div_quo;
    logic [DATA_W-1:0]       div_rem;
    logic [DATA_W-1:0]       t_square;
    logic [DATA_W-1:0]       f2_d;
    logic [DATA_W-1:0]       t_hi;
    logic [DATA_W-1:0]       recip_in;
    logic [2*DATA_W-1:0]     recip_prod;
    logic [DATA_W-1:0]       third;
    logic [DATA_W-1:0]       sixth;
    logic [DATA_W-1:0]       mod6;
    btg_alg_t                alg;

    assign phase_inc = {1'b0, phase_reg} + 1'b1;
    assign wrap      = phase_inc >= {1'b0, period_hold_reg};
    assign period_in = PERIOD_WIDTH'(s_period_samples);
    assign t_square  = t_reg * t_reg;
    assign f2_d      = F2_BASE_C + {30'd0, t_reg[11:10] & t_reg[15:14]};

    // division by three through the reciprocal, shared by t / 3 and (t >> 14) % 6
    assign t_hi       = {14'd0, t_reg[31:14]};
    assign recip_in   = (cmd.op == OP_F2_DIV3) ? t_reg : t_hi;
    assign recip_prod = {{DATA_W{1'b0}}, recip_in} * {{DATA_W{1'b0}}, RECIP3_C};
    assign third      = DATA_W'(recip_prod >> RECIP3_SHIFT);
    assign sixth      = third >> 1;
    assign mod6       = t_hi - sixth * F0_MOD_C;

    always_comb begin
        unique case (algorithm_reg)
            ALG_CODE_F0: alg = ALG_F0;
            ALG_CODE_F1: alg = ALG_F1;
            ALG_CODE_F2: alg = ALG_F2;
            default:     alg = ALG_PASS;
        endcase
    end

    assign status.wrap     = wrap;
    assign status.div_busy = div_busy;
    assign status.alg      = alg;

    // divider operand select
    always_comb begin
        div_start    = 1'b0;
        div_dividend = t_reg;
        div_divisor  = f2_d;
        unique case (cmd.op)
            OP_DIV_TM: begin
                div_start   = 1'b1;
                div_divisor = F0_SUB_C - x_reg;
            end
            OP_DIV_XD: begin
                div_start    = 1'b1;
                div_dividend = x_reg;
                div_divisor  = f2_d;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    btg_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        algorithm_next   = algorithm_reg;
        offset_next      = offset_reg;
        phase_next       = phase_reg;
        period_hold_next = period_hold_reg;
        step_next        = step_reg;
        held_next        = held_reg;
        fresh_next       = fresh_reg;
        t_next           = t_reg;
        x_next           = x_reg;
        y_next           = y_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ALGORITHM:    algorithm_next = cfg_wr_data[ALG_W-1:0];
                CFG_START_OFFSET: offset_next    = cfg_wr_data[OFFSET_W-1:0];
                default:          ;
            endcase
        end

        unique case (cmd.op)
            OP_TICK: begin
                fresh_next = wrap;
                if (wrap) begin
                    phase_next       = '0;
                    period_hold_next = (period_in == '0) ? PERIOD_WIDTH'(1) : period_in;
                    t_next           = step_reg + DATA_W'(offset_reg);
                    step_next        = step_reg + 1'b1;
                end else begin
                    phase_next = phase_inc[PERIOD_WIDTH-1:0];
                end
            end
            OP_F0_MUL351: x_next = t_reg * F0_MUL_C;
            OP_F0_MOD6: begin
                x_next = div_rem;
                y_next = mod6;
            end
            OP_F0_MULAK:  x_next = x_reg * (y_reg + F0_BASE_C);
            OP_F0_MUL200: y_next = t_reg * F0_MASK_C;
            OP_F0_FIN:    held_next = x_reg | (y_reg & (t_reg >> 3));
            OP_F1_MUL:    x_next = t_reg * (t_reg >> t_reg[14:11]);
            OP_F1_FIN:    held_next = t_reg[9] ? (x_reg << 2) : '0;
            OP_F2_DIV3:   y_next = (t_reg >> 11) ^ (third >> 12);
            OP_F2_SQ:     x_next = t_reg[9] ? '0 : (t_square << 3);
            OP_MUL_XY:    x_next = x_reg * y_reg;
            OP_F2_FIN:    held_next = (t_reg >> 4) | div_quo;
            OP_PASS_FIN:  held_next = t_reg;
            default:      ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            algorithm_reg   <= '0;
            offset_reg      <= '0;
            phase_reg       <= '0;
            period_hold_reg <= PERIOD_WIDTH'(1);
            step_reg        <= '0;
            held_reg        <= '0;
            fresh_reg       <= 1'b0;
        end else begin
            algorithm_reg   <= algorithm_next;
            offset_reg      <= offset_next;
            phase_reg       <= phase_next;
            period_hold_reg <= period_hold_next;
            step_reg        <= step_next;
            held_reg        <= held_next;
            fresh_reg       <= fresh_next;
        end
    end

    always_ff @(posedge aclk) begin
        t_reg <= t_next;
        x_reg <= x_next;
        y_reg <= y_next;
        if (cmd.load_out) begin
            out_value_reg <= held_reg;
            out_fresh_reg <= fresh_reg;
        end
    end

    assign m_sample_value = out_value_reg;
    assign m_fresh_value  = out_fresh_reg;

    a_phase_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg < period_hold_reg)
        else $error("phase outside held period");

    a_wrap_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_TICK) |=> (fresh_reg == $past(wrap)) && (phase_reg == '0) == fresh_reg)
        else $error("fresh flag disagrees with phase wrap");

endmodule

// ===== design/btg_ctrl.sv =====
// sequencer for tick handling, formula steps and output transfer
module btg_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  btg_pkg::btg_status_t status,
    output btg_pkg::btg_cmd_t    cmd
);
    import btg_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_F0_MUL351,
        ST_F0_DIVM,
        ST_F0_WAITM,
        ST_F0_MOD6,
        ST_F0_MULAK,
        ST_F0_MUL200,
        ST_F0_FIN,
        ST_F1_MUL,
        ST_F1_FIN,
        ST_F2_DIV3,
        ST_F2_SQ,
        ST_F2_MULC,
        ST_F2_DIVD,
        ST_F2_WAITD,
        ST_F2_FIN,
        ST_PASS_FIN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.op       = OP_NONE;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op = OP_TICK;
                    if (status.wrap) begin
                        unique case (status.alg)
                            ALG_F0:   state_next = ST_F0_MUL351;
                            ALG_F1:   state_next = ST_F1_MUL;
                            ALG_F2:   state_next = ST_F2_DIV3;
                            default:  state_next = ST_PASS_FIN;
                        endcase
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_F0_MUL351: begin
                cmd.op     = OP_F0_MUL351;
                state_next = ST_F0_DIVM;
            end
            ST_F0_DIVM: begin
                cmd.op     = OP_DIV_TM;
                state_next = ST_F0_WAITM;
            end
            ST_F0_WAITM: begin
                if (!status.div_busy) begin
                    state_next = ST_F0_MOD6;
                end
            end
            ST_F0_MOD6: begin
                cmd.op     = OP_F0_MOD6;
                state_next = ST_F0_MULAK;
            end
            ST_F0_MULAK: begin
                cmd.op     = OP_F0_MULAK;
                state_next = ST_F0_MUL200;
            end
            ST_F0_MUL200: begin
                cmd.op     = OP_F0_MUL200;
                state_next = ST_F0_FIN;
            end
            ST_F0_FIN: begin
                cmd.op     = OP_F0_FIN;
                state_next = ST_DONE;
            end
            ST_F1_MUL: begin
                cmd.op     = OP_F1_MUL;
                state_next = ST_F1_FIN;
            end
            ST_F1_FIN: begin
                cmd.op     = OP_F1_FIN;
                state_next = ST_DONE;
            end
            ST_F2_DIV3: begin
                cmd.op     = OP_F2_DIV3;
                state_next = ST_F2_SQ;
            end
            ST_F2_SQ: begin
                cmd.op     = OP_F2_SQ;
                state_next = ST_F2_MULC;
            end
            ST_F2_MULC: begin
                cmd.op     = OP_MUL_XY;
                state_next = ST_F2_DIVD;
            end
            ST_F2_DIVD: begin
                cmd.op     = OP_DIV_XD;
                state_next = ST_F2_WAITD;
            end
            ST_F2_WAITD: begin
                if (!status.div_busy) begin
                    state_next = ST_F2_FIN;
                end
            end
            ST_F2_FIN: begin
                cmd.op     = OP_F2_FIN;
                state_next = ST_DONE;
            end
            ST_PASS_FIN: begin
                cmd.op     = OP_PASS_FIN;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // wait for a free output register
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("output overwritten before transfer");

    a_hold_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !status.wrap) |=> (state_reg == ST_DONE))
        else $error("holding tick did not go straight to output");

endmodule

// ===== design/bytebeat_tone_generator_unit.sv =====
// bytebeat tone generator top level
// from input transfer to result: a holding tick goes straight to the output register; a fresh
// tick first runs the formula steps of the selected algorithm (pass-through, formula 0, 1 or 2),
// formulas 0 and 2 each with one pass through the 32-step shared divider
// one tick at a time: next input transfer in the cycle the result first shows; a waiting result
// holds the sequencer. synchronous active-low reset: phase 0, period 1
module bytebeat_tone_generator_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [btg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [btg_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [btg_pkg::IN_W-1:0]       s_period_samples,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [btg_pkg::DATA_W-1:0]     m_sample_value,
    output logic                           m_fresh_value
);
    import btg_pkg::*;

    btg_cmd_t    cmd;
    btg_status_t status;

    btg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    btg_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_period_samples (s_period_samples),
        .m_sample_value   (m_sample_value),
        .m_fresh_value    (m_fresh_value)
    );

endmodule
